### hdl/sotbl_pkg.sv
// shared types and constants for the sorted table insert/remove unit
`default_nettype none

package sotbl_pkg;

    // default table depth
    localparam int unsigned DEPTH_DEF = 16;

    // field widths of the request and result
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 5;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // compare unit result
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

`default_nettype wire

### hdl/sorted_table_insert_remove_unit.sv
// top level: sorted table of signed values with insert, remove, search and clear
//
//  channel   dir  handshake           payload
//  request   in   i_valid / o_stall   i_mode, i_value
//  result    out  o_valid / i_stall   o_status, o_position, o_count
//
// one request at a time; o_stall is high from acceptance until its result is taken
// scan reads and compares the entries below the value one by one in S_SCAN and S_CMP, and stops
// at the end of the table or at the first entry not below it, then passes through S_DECIDE;
// an insert or remove then moves each entry with a read and a write over the single ram port pair
// clear goes from acceptance straight to the result state
// reset empties the table at once; no clearing pass, stale entries are never read
// the result holds in its register while i_stall is high
`default_nettype none

module sorted_table_insert_remove_unit #(
    parameter int unsigned DEPTH = sotbl_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [sotbl_pkg::MODE_W-1:0]       i_mode,
    input  wire logic signed [sotbl_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [sotbl_pkg::STATUS_W-1:0]          o_status,
    output logic [sotbl_pkg::POS_W-1:0]             o_position,
    output logic [sotbl_pkg::POS_W-1:0]             o_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = sotbl_pkg::VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_DECIDE,
        S_SHR,
        S_SHR_WR,
        S_SHL,
        S_SHL_WR,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_j, n_j;
    logic               r_hit, n_hit;
    sotbl_pkg::t_mode   r_mode, n_mode;
    sotbl_pkg::t_status r_status, n_status;
    logic [VW-1:0]      r_value, n_value;

    logic               req_accept;
    logic [CW-1:0]      j_inc, j_dec;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VW-1:0]      ram_wdata, ram_rdata;
    sotbl_pkg::t_cmp_res cmp_res;

    // entry storage
    sotbl_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // compare of the read entry against the request value
    sotbl_cmp u_cmp (
        .i_entry (ram_rdata),
        .i_key   (r_value),
        .o_res   (cmp_res)
    );

    assign req_accept = i_valid && !o_stall;
    assign j_inc      = r_j + CW'(1);
    assign j_dec      = r_j - CW'(1);

    // sequencer next state and ram control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_j       = r_j;
        n_hit     = r_hit;
        n_mode    = r_mode;
        n_status  = r_status;
        n_value   = r_value;
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_mode   = sotbl_pkg::t_mode'(i_mode);
                    n_value  = i_value;
                    n_idx    = '0;
                    n_status = sotbl_pkg::ST_OK;
                    if (sotbl_pkg::t_mode'(i_mode) == sotbl_pkg::MODE_CLEAR) begin
                        n_count = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            // read the next entry or stop at the end of the table
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_hit   = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = S_CMP;
                end
            end
            // step past smaller entries, stop at the first not below the value
            S_CMP: begin
                if (cmp_res.lt) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_hit   = cmp_res.eq;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_mode)
                    sotbl_pkg::MODE_INSERT: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = sotbl_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_j     = r_count;
                            n_state = S_SHR;
                        end
                    end
                    sotbl_pkg::MODE_REMOVE: begin
                        if (!r_hit) begin
                            n_status = sotbl_pkg::ST_MISS;
                            n_state  = S_OUT;
                        end else begin
                            n_j     = r_idx;
                            n_state = S_SHL;
                        end
                    end
                    sotbl_pkg::MODE_SEARCH: begin
                        n_status = r_hit ? sotbl_pkg::ST_OK : sotbl_pkg::ST_MISS;
                        n_state  = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            // open a gap at the insert position, moving entries up from the top
            S_SHR: begin
                if (r_j == r_idx) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = r_value;
                    n_count   = r_count + CW'(1);
                    n_state   = S_OUT;
                end else begin
                    ram_raddr = j_dec[AW-1:0];
                    n_state   = S_SHR_WR;
                end
            end
            S_SHR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = j_dec;
                n_state   = S_SHR;
            end
            // close the gap at the removed position, moving entries down
            S_SHL: begin
                if (j_inc >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_OUT;
                end else begin
                    ram_raddr = j_inc[AW-1:0];
                    n_state   = S_SHL_WR;
                end
            end
            S_SHL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = j_inc;
                n_state   = S_SHL;
            end
            // hold the result until taken
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_hit    <= n_hit;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_status   = r_status;
    assign o_position = sotbl_pkg::POS_W'(r_idx);
    assign o_count    = sotbl_pkg::POS_W'(r_count);

    // count never goes past the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a full status is only reported on a full table
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == sotbl_pkg::ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

    // reported position never lies beyond the entry count
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx <= r_count))
        else $error("position beyond count");

    // an upward move always stays above the insert position
    a_shift_above_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHR_WR) |-> (r_j > r_idx))
        else $error("shift below insert position");

endmodule

`default_nettype wire

### hdl/sotbl_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sotbl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]                  i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic      [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/sotbl_cmp.sv
// signed less-than and equality compare unit
`default_nettype none

module sotbl_cmp (
    input  wire logic [sotbl_pkg::VALUE_W-1:0] i_entry,
    input  wire logic [sotbl_pkg::VALUE_W-1:0] i_key,
    output sotbl_pkg::t_cmp_res                o_res
);

    // entry below key, and entry equal to key
    always_comb begin
        o_res.lt = ($signed(i_entry) < $signed(i_key));
        o_res.eq = (i_entry == i_key);
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for the sorted table insert/remove unit: directed and random requests, checked results

module tb_top;

    localparam int unsigned DEPTH          = sotbl_pkg::DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned PRINT_CAP      = 100;

    typedef logic [sotbl_pkg::POS_W-1:0] t_pos;
    typedef logic signed [sotbl_pkg::VALUE_W-1:0] t_val;

    // one expected result
    typedef struct {
        sotbl_pkg::t_status status;
        t_pos               position;
        t_pos               count;
        int unsigned        seq;
    } t_table_result;

    // clock, reset and block ports
    logic                                i_clk     = 1'b0;
    logic                                i_rst_n   = 1'b0;
    logic                                i_valid   = 1'b0;
    logic                                o_stall;
    sotbl_pkg::t_mode                    req_mode  = sotbl_pkg::MODE_INSERT;
    t_val                                req_value = '0;
    logic                                o_valid;
    logic                                i_stall   = 1'b0;
    logic [sotbl_pkg::STATUS_W-1:0]      o_status;
    logic [sotbl_pkg::POS_W-1:0]         o_position;
    logic [sotbl_pkg::POS_W-1:0]         o_count;

    // shadow copy of the table, kept in ascending order
    t_val                      held_values[$];
    t_table_result             pending_results[$];

    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned request_seq     = 0;
    int unsigned burst_left      = 0;
    bit          sender_gaps_on  = 1'b1;
    int unsigned holdoff_req_cnt = 0;
    int unsigned holdoff_granted = 0;
    int unsigned holdoff_left    = 0;
    int unsigned stall_style     = 0;
    int unsigned style_left      = 0;

    sorted_table_insert_remove_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_mode    (req_mode),
        .i_value   (req_value),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_position(o_position),
        .o_count   (o_count)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // apply one operation to the shadow table and return its result
    function automatic t_table_result predict_table_op(sotbl_pkg::t_mode op, t_val val);
        t_table_result res;
        int unsigned   lb;
        bit            hit;
        res.status   = sotbl_pkg::ST_OK;
        res.position = '0;
        res.seq      = request_seq;
        if (op == sotbl_pkg::MODE_CLEAR) begin
            held_values.delete();
        end else begin
            // count of entries strictly below the value
            lb = 0;
            while (lb < held_values.size() && held_values[lb] < val)
                lb++;
            hit = (lb < held_values.size()) && (held_values[lb] == val);
            case (op)
                sotbl_pkg::MODE_INSERT: begin
                    if (held_values.size() >= DEPTH)
                        res.status = sotbl_pkg::ST_FULL;
                    else if (lb == held_values.size())
                        held_values.push_back(val);
                    else
                        held_values.insert(lb, val);
                end
                sotbl_pkg::MODE_REMOVE: begin
                    if (!hit)
                        res.status = sotbl_pkg::ST_MISS;
                    else
                        held_values.delete(lb);
                end
                default: begin
                    res.status = hit ? sotbl_pkg::ST_OK : sotbl_pkg::ST_MISS;
                end
            endcase
            res.position = t_pos'(lb);
        end
        res.count = t_pos'(held_values.size());
        return res;
    endfunction

    // print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // offer one request, wait for it to be taken, then pace the sender
    task automatic send_request(input sotbl_pkg::t_mode op, input t_val val);
        int unsigned gap;
        req_mode  <= op;
        req_value <= val;
        i_valid   <= 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_results.push_back(predict_table_op(op, val));
        request_seq++;
        if (sender_gaps_on) begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                gap        = $urandom_range(12, 1);
                burst_left = $urandom_range(30, 1);
                i_valid   <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering and wait for every pending result
    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // operation mix for the current phase
    function automatic sotbl_pkg::t_mode pick_mode(int unsigned bias);
        int unsigned r;
        int unsigned ins_lim;
        int unsigned rem_lim;
        int unsigned srch_lim;
        r = $urandom_range(99);
        case (bias)
            0: begin ins_lim = 65; rem_lim = 80; srch_lim = 97; end
            1: begin ins_lim = 15; rem_lim = 75; srch_lim = 97; end
            default: begin ins_lim = 35; rem_lim = 65; srch_lim = 97; end
        endcase
        if (r < ins_lim)
            return sotbl_pkg::MODE_INSERT;
        else if (r < rem_lim)
            return sotbl_pkg::MODE_REMOVE;
        else if (r < srch_lim)
            return sotbl_pkg::MODE_SEARCH;
        else
            return sotbl_pkg::MODE_CLEAR;
    endfunction

    // operand: small pool for duplicates, held entries for hits, extremes, full range
    function automatic t_val pick_value();
        t_val        v;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) begin
            v = $urandom_range(8);
            v = v - 4;
        end else if (r < 60 && held_values.size() != 0) begin
            v = held_values[$urandom_range(held_values.size() - 1)];
        end else if (r < 75) begin
            case ($urandom_range(5))
                0: v = 32'sh8000_0000;
                1: v = 32'sh8000_0001;
                2: v = 32'sh7fff_ffff;
                3: v = 32'sh7fff_fffe;
                4: v = '0;
                default: v = -1;
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    // receiver stall pattern, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else if (holdoff_granted != holdoff_req_cnt) begin
            holdoff_granted++;
            holdoff_left = HOLDOFF_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(3);
                style_left  = $urandom_range(200, 10);
            end
            style_left--;
            case (stall_style)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(3) == 0);
                2: i_stall <= ($urandom_range(3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_table_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: status %0d pos %0d cnt %0d",
                                          o_status, o_position, o_count));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("request %0d status: got %0d expected %0d",
                                              exp_res.seq, o_status, exp_res.status));
                if (o_position !== exp_res.position)
                    report_mismatch($sformatf("request %0d position: got %0d expected %0d",
                                              exp_res.seq, o_position, exp_res.position));
                if (o_count !== exp_res.count)
                    report_mismatch($sformatf("request %0d count: got %0d expected %0d",
                                              exp_res.seq, o_count, exp_res.count));
            end
        end
    end

    // lookups and clear on an empty table
    task automatic test_empty_table();
        send_request(sotbl_pkg::MODE_SEARCH, 5);
        send_request(sotbl_pkg::MODE_REMOVE, 5);
        send_request(sotbl_pkg::MODE_CLEAR, $urandom());
    endtask

    // extreme values, duplicates ahead of equals, remove of the first equal, miss
    task automatic test_extremes_and_duplicates();
        send_request(sotbl_pkg::MODE_INSERT, 32'sh7fff_ffff);
        send_request(sotbl_pkg::MODE_INSERT, 32'sh8000_0000);
        send_request(sotbl_pkg::MODE_INSERT, -1);
        send_request(sotbl_pkg::MODE_INSERT, -1);
        send_request(sotbl_pkg::MODE_SEARCH, -1);
        send_request(sotbl_pkg::MODE_REMOVE, -1);
        send_request(sotbl_pkg::MODE_REMOVE, 32'sh7fff_ffff);
        send_request(sotbl_pkg::MODE_REMOVE, 32'sh7fff_ffff);
    endtask

    // fill to capacity, insert into full table, miss past the end, clear
    task automatic test_full_table();
        int i;
        for (i = 0; held_values.size() < DEPTH; i++)
            send_request(sotbl_pkg::MODE_INSERT, (i % 2) ? i * 3 : -i * 5);
        send_request(sotbl_pkg::MODE_INSERT, 32'sh7fff_ffff);
        send_request(sotbl_pkg::MODE_SEARCH, 32'sh7fff_ffff);
        send_request(sotbl_pkg::MODE_CLEAR, $urandom());
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_holdoff_backpressure();
        int i;
        holdoff_req_cnt++;
        sender_gaps_on = 1'b0;
        for (i = 0; i < 10; i++)
            send_request(pick_mode(2), pick_value());
        sender_gaps_on = 1'b1;
        wait_all_results();
    endtask

    // random phases biased toward filling, draining or mixed traffic
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_left;
        int unsigned bias;
        sent       = 0;
        phase_left = 0;
        bias       = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                bias       = $urandom_range(2);
                phase_left = $urandom_range(80, 20);
            end
            phase_left--;
            send_request(pick_mode(bias), pick_value());
            sent++;
            // sender pauses now and then until everything is back
            if (sent % 350 == 0)
                wait_all_results();
            if (sent == RANDOM_ITEMS / 2)
                test_holdoff_backpressure();
        end
    endtask

    // test sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_extremes_and_duplicates();
        test_full_table();
        test_holdoff_backpressure();
        test_random_traffic();
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
